// ----- hdl/rsc_pkg.sv -----
// Shared types, codes and constants of the RSSI calibration search.
`default_nettype none
package rsc_pkg;

  localparam int FINE_W     = 12;
  localparam int RSSI_W     = 16;
  localparam int COARSE_W   = 5;
  localparam int STEP_W     = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [COARSE_W-1:0] COARSE_MAX       = 5'd31;
  localparam logic [STEP_W-1:0]   COARSE_STEP_INIT = 4'd8;
  localparam logic [FINE_W-1:0]   CODE_MAX_RST     = 12'd2047;
  localparam logic [COARSE_W-1:0] COARSE_INIT_RST  = 5'd16;

  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_MEASURE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_BELOW    = 2'd1,
    ST_NO_ABOVE    = 2'd2,
    ST_COARSE_FAIL = 2'd3
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CODE_MAX       = 2'd0,
    REG_TARGET_RSSI    = 2'd1,
    REG_COARSE_INITIAL = 2'd2,
    REG_COARSE_ENABLE  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic running;
    logic below;
    logic above;
  } flags_t;

  typedef struct packed {
    logic [COARSE_W-1:0] value;
    logic [STEP_W-1:0]   step;
  } coarse_t;

  typedef struct packed {
    logic    done;
    status_t status;
  } result_t;

endpackage
`default_nettype wire

// ----- hdl/rsc_in_stage.sv -----
// Input register stage: holds one accepted transaction until the step logic takes it.
`default_nettype none
module rsc_in_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic                      in_action,
  input  wire logic [rsc_pkg::RSSI_W-1:0] in_rssi,
  input  wire logic                      advance,
  output logic                           valid_r,
  output rsc_pkg::action_t               action_r,
  output logic [rsc_pkg::RSSI_W-1:0]     rssi_r
);

  logic accept;

  assign in_tready = !valid_r || advance;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= rsc_pkg::action_t'(in_action);
      rssi_r   <= in_rssi;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/rsc_step.sv -----
// Next-state logic of the binary search and the coarse resistor loop for one transaction.
`default_nettype none
module rsc_step #(
  parameter int CODE_WIDTH = 12
) (
  input  wire rsc_pkg::action_t             action,
  input  wire logic [rsc_pkg::RSSI_W-1:0]   rssi,
  input  wire logic [CODE_WIDTH-1:0]        code_max,
  input  wire logic [rsc_pkg::RSSI_W-1:0]   target_rssi,
  input  wire logic [rsc_pkg::COARSE_W-1:0] coarse_initial,
  input  wire logic                         coarse_enable,
  input  wire logic [CODE_WIDTH-1:0]        code,
  input  wire logic [CODE_WIDTH-1:0]        span,
  input  wire rsc_pkg::flags_t              flags,
  input  wire rsc_pkg::coarse_t             coarse,
  output logic [CODE_WIDTH-1:0]             code_nxt,
  output logic [CODE_WIDTH-1:0]             span_nxt,
  output rsc_pkg::flags_t                   flags_nxt,
  output rsc_pkg::coarse_t                  coarse_nxt,
  output rsc_pkg::result_t                  result
);

  logic [CODE_WIDTH:0]   cm_plus1;
  logic [CODE_WIDTH-1:0] half;
  logic [CODE_WIDTH-1:0] adj;
  logic                  is_low;
  logic [CODE_WIDTH:0]   moved;
  logic [CODE_WIDTH-1:0] clamped;
  logic [CODE_WIDTH-1:0] span_half;
  logic                  below_n;
  logic                  above_n;
  logic [rsc_pkg::COARSE_W:0] up_sum;
  logic [rsc_pkg::COARSE_W-1:0] up_val;
  logic [rsc_pkg::COARSE_W-1:0] down_val;

  assign cm_plus1  = {1'b0, code_max} + {{CODE_WIDTH{1'b0}}, 1'b1};
  assign half      = cm_plus1[CODE_WIDTH:1];
  assign adj       = span >> 1;
  assign span_half = span >> 1;
  assign is_low    = rssi < target_rssi;
  assign below_n   = flags.below || is_low;
  assign above_n   = flags.above || !is_low;

  always_comb begin
    if (is_low) begin
      moved = (adj > code) ? '0 : {1'b0, code - adj};
    end else begin
      moved = {1'b0, code} + {1'b0, adj};
    end
    clamped = (moved > {1'b0, code_max}) ? code_max : moved[CODE_WIDTH-1:0];
  end

  assign up_sum   = {1'b0, coarse.value} + {2'b00, coarse.step};
  assign up_val   = (up_sum > {1'b0, rsc_pkg::COARSE_MAX}) ? rsc_pkg::COARSE_MAX
                                                           : up_sum[rsc_pkg::COARSE_W-1:0];
  assign down_val = ({1'b0, coarse.step} > coarse.value) ? '0 : coarse.value - {1'b0, coarse.step};

  always_comb begin
    code_nxt      = code;
    span_nxt      = span;
    flags_nxt     = flags;
    coarse_nxt    = coarse;
    result.done   = 1'b0;
    result.status = rsc_pkg::ST_OK;
    case (action)
      rsc_pkg::ACT_START: begin
        coarse_nxt.value  = coarse_initial;
        coarse_nxt.step   = rsc_pkg::COARSE_STEP_INIT;
        flags_nxt.running = 1'b1;
        flags_nxt.below   = 1'b0;
        flags_nxt.above   = 1'b0;
        code_nxt          = half;
        span_nxt          = half;
      end
      rsc_pkg::ACT_MEASURE: begin
        if (flags.running) begin
          code_nxt        = clamped;
          span_nxt        = span_half;
          flags_nxt.below = below_n;
          flags_nxt.above = above_n;
          if (span_half == '0) begin
            if (below_n && above_n) begin
              flags_nxt.running = 1'b0;
              result.done       = 1'b1;
            end else if (!coarse_enable) begin
              flags_nxt.running = 1'b0;
              result.done       = 1'b1;
              result.status     = !below_n ? rsc_pkg::ST_NO_BELOW : rsc_pkg::ST_NO_ABOVE;
            end else if (!below_n) begin
              // Never undershot: the coarse resistor goes down and the search restarts.
              if (coarse.value == '0 || coarse.step == '0) begin
                flags_nxt.running = 1'b0;
                result.done       = 1'b1;
                result.status     = rsc_pkg::ST_COARSE_FAIL;
              end else begin
                coarse_nxt.value = down_val;
                coarse_nxt.step  = coarse.step >> 1;
                flags_nxt.below  = 1'b0;
                flags_nxt.above  = 1'b0;
                code_nxt         = half;
                span_nxt         = half;
              end
            end else begin
              if (coarse.value == rsc_pkg::COARSE_MAX || coarse.step == '0) begin
                flags_nxt.running = 1'b0;
                result.done       = 1'b1;
                result.status     = rsc_pkg::ST_COARSE_FAIL;
              end else begin
                coarse_nxt.value = up_val;
                coarse_nxt.step  = coarse.step >> 1;
                flags_nxt.below  = 1'b0;
                flags_nxt.above  = 1'b0;
                code_nxt         = half;
                span_nxt         = half;
              end
            end
          end
        end
      end
      default: begin
        code_nxt = code;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/rssi_successive_approx_calibrator.sv -----
// Top level of the RSSI successive-approximation calibrator: configuration, state and result register.
// Every transaction, a start or a measurement, yields exactly one result transaction. The block
// takes one transaction per cycle while the result side is not stalling it. A transaction is held
// in the input register and passes from there through the search step logic into the result
// register. The rate is set by the update of the search code, span and coarse registers, which
// each transaction reads and writes. The input register can take a new transaction while a
// finished one waits in the result register. out_tlast marks the transaction ending a calibration.
`default_nettype none
module rssi_successive_approx_calibrator #(
  parameter int CODE_WIDTH = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [rsc_pkg::RSSI_W-1:0]    in_tdata,   // [15:0] rssi
  input  wire logic                          in_tuser,   // [0] action
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [rsc_pkg::OUT_DATA_W-1:0]     out_tdata,  // [11:0] fine_code, [16:12] coarse_code,
                                                         // [18:17] status, [23:19] zero
  output logic                               out_tlast,  // done_res
  input  wire logic                          cfg_we,
  input  wire logic [rsc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [rsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int MW = (CODE_WIDTH > rsc_pkg::FINE_W) ? CODE_WIDTH : rsc_pkg::FINE_W;
  localparam logic [MW-1:0] CM_RST_EXT = MW'(rsc_pkg::CODE_MAX_RST);

  logic [CODE_WIDTH-1:0]        code_max_r;
  logic [rsc_pkg::RSSI_W-1:0]   target_rssi_r;
  logic [rsc_pkg::COARSE_W-1:0] coarse_initial_r;
  logic                         coarse_enable_r;
  logic [MW-1:0]                cm_wr_ext;

  logic [CODE_WIDTH-1:0] code_r, code_nxt;
  logic [CODE_WIDTH-1:0] span_r, span_nxt;
  rsc_pkg::flags_t       flags_r, flags_nxt;
  rsc_pkg::coarse_t      coarse_r, coarse_nxt;
  rsc_pkg::result_t      result;

  logic                       advance;
  logic                       st_valid;
  rsc_pkg::action_t           st_action;
  logic [rsc_pkg::RSSI_W-1:0] st_rssi;
  logic [MW-1:0]              fine_ext;

  logic                              out_valid_r;
  logic [rsc_pkg::FINE_W-1:0]        fine_r;
  logic [rsc_pkg::COARSE_W-1:0]      coarse_out_r;
  rsc_pkg::result_t                  result_r;

  assign cm_wr_ext = MW'(cfg_wdata[rsc_pkg::FINE_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_max_r       <= CM_RST_EXT[CODE_WIDTH-1:0];
      target_rssi_r    <= '0;
      coarse_initial_r <= rsc_pkg::COARSE_INIT_RST;
      coarse_enable_r  <= 1'b1;
    end else if (cfg_we) begin
      case (rsc_pkg::cfg_reg_t'(cfg_addr))
        rsc_pkg::REG_CODE_MAX:       code_max_r       <= cm_wr_ext[CODE_WIDTH-1:0];
        rsc_pkg::REG_TARGET_RSSI:    target_rssi_r    <= cfg_wdata;
        rsc_pkg::REG_COARSE_INITIAL: coarse_initial_r <= cfg_wdata[rsc_pkg::COARSE_W-1:0];
        rsc_pkg::REG_COARSE_ENABLE:  coarse_enable_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign advance = st_valid && (!out_valid_r || out_tready);

  rsc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (in_tuser),
    .in_rssi   (in_tdata),
    .advance   (advance),
    .valid_r   (st_valid),
    .action_r  (st_action),
    .rssi_r    (st_rssi)
  );

  rsc_step #(
    .CODE_WIDTH (CODE_WIDTH)
  ) u_step (
    .action         (st_action),
    .rssi           (st_rssi),
    .code_max       (code_max_r),
    .target_rssi    (target_rssi_r),
    .coarse_initial (coarse_initial_r),
    .coarse_enable  (coarse_enable_r),
    .code           (code_r),
    .span           (span_r),
    .flags          (flags_r),
    .coarse         (coarse_r),
    .code_nxt       (code_nxt),
    .span_nxt       (span_nxt),
    .flags_nxt      (flags_nxt),
    .coarse_nxt     (coarse_nxt),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r   <= '0;
      span_r   <= '0;
      flags_r  <= '0;
      coarse_r <= '{value: rsc_pkg::COARSE_INIT_RST, step: rsc_pkg::COARSE_STEP_INIT};
    end else if (advance) begin
      code_r   <= code_nxt;
      span_r   <= span_nxt;
      flags_r  <= flags_nxt;
      coarse_r <= coarse_nxt;
    end
  end

  assign fine_ext = MW'(code_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fine_r       <= fine_ext[rsc_pkg::FINE_W-1:0];
      coarse_out_r <= coarse_nxt.value;
      result_r     <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = result_r.done;
  assign out_tdata  = {5'd0, result_r.status, coarse_out_r, fine_r};

endmodule
`default_nettype wire

// ----- hdl/rsc_checker.sv -----
// Port-level checks of the RSSI calibrator and their binding to the top level.
`default_nettype none
module rsc_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [rsc_pkg::OUT_DATA_W-1:0]   out_tdata,
  input wire logic                             out_tlast
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Status is only reported on the transaction that ends a calibration.
  a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[18:17] == 2'd0)
    else $error("nonzero status without done");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready right after reset");

endmodule

bind rssi_successive_approx_calibrator rsc_checker u_rsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

// ----- tb/tb_rssi_successive_approx_calibrator.sv -----
// Self-checking testbench for the RSSI successive-approximation calibrator.
`default_nettype none
module tb_rssi_successive_approx_calibrator;

  localparam int RSSI_BITS = rsc_pkg::RSSI_W;
  localparam int CFG_BITS  = rsc_pkg::CFG_DATA_W;

  typedef struct packed {
    logic [rsc_pkg::FINE_W-1:0]   fine;
    logic [rsc_pkg::COARSE_W-1:0] coarse;
    logic                         done;
    rsc_pkg::status_t             status;
  } calib_result_t;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    rsc_pkg::action_t   act;
    rsc_pkg::cfg_reg_t  reg_id;
    logic [15:0]        value;
    logic               typed;
    calib_result_t      want;
  } row_t;

  localparam calib_result_t NO_EXP = '0;
  localparam int PLAN_LEN = 39;
  localparam int HOLD_CYCLES = 300;

  // Directed sequence. Configuration rows are applied once the block has gone idle.
  localparam row_t PLAN [PLAN_LEN] = '{
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'h0000, 1'b1,
      '{12'd0, 5'd16, 1'b0, rsc_pkg::ST_OK}},
    '{ROW_CFG,  rsc_pkg::ACT_START, rsc_pkg::REG_CODE_MAX,       16'd3,    1'b0, NO_EXP},
    '{ROW_CFG,  rsc_pkg::ACT_START, rsc_pkg::REG_TARGET_RSSI,    16'h8000, 1'b0, NO_EXP},
    '{ROW_CFG,  rsc_pkg::ACT_START, rsc_pkg::REG_COARSE_INITIAL, 16'd31,   1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_START, rsc_pkg::REG_CODE_MAX, 16'hFFFF, 1'b1,
      '{12'd2, 5'd31, 1'b0, rsc_pkg::ST_OK}},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'hFFFF, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'hFFFF, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'h0000, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'h7FFF, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'h8000, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'h0001, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'hFFFF, 1'b0, NO_EXP},
    '{ROW_CFG,  rsc_pkg::ACT_START, rsc_pkg::REG_COARSE_INITIAL, 16'd30,   1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_START,   rsc_pkg::REG_CODE_MAX, 16'h0000, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'h0000, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_START,   rsc_pkg::REG_CODE_MAX, 16'h0000, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'h0000, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'h0000, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'h0000, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'h0000, 1'b1,
      '{12'd1, 5'd31, 1'b1, rsc_pkg::ST_COARSE_FAIL}},
    '{ROW_CFG,  rsc_pkg::ACT_START, rsc_pkg::REG_CODE_MAX,       16'd1,    1'b0, NO_EXP},
    '{ROW_CFG,  rsc_pkg::ACT_START, rsc_pkg::REG_COARSE_INITIAL, 16'd16,   1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_START,   rsc_pkg::REG_CODE_MAX, 16'hFFFF, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'hFFFF, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'hFFFF, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'hFFFF, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'hFFFF, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'hFFFF, 1'b1,
      '{12'd1, 5'd1, 1'b1, rsc_pkg::ST_COARSE_FAIL}},
    '{ROW_CFG,  rsc_pkg::ACT_START, rsc_pkg::REG_COARSE_INITIAL, 16'd3,    1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_START,   rsc_pkg::REG_CODE_MAX, 16'h0000, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'hFFFF, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'hFFFF, 1'b1,
      '{12'd1, 5'd0, 1'b1, rsc_pkg::ST_COARSE_FAIL}},
    '{ROW_CFG,  rsc_pkg::ACT_START, rsc_pkg::REG_CODE_MAX,       16'd0,    1'b0, NO_EXP},
    '{ROW_CFG,  rsc_pkg::ACT_START, rsc_pkg::REG_COARSE_ENABLE,  16'd0,    1'b0, NO_EXP},
    '{ROW_CFG,  rsc_pkg::ACT_START, rsc_pkg::REG_TARGET_RSSI,    16'hFFFF, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_START, rsc_pkg::REG_CODE_MAX, 16'h1234, 1'b1,
      '{12'd0, 5'd3, 1'b0, rsc_pkg::ST_OK}},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'hFFFF, 1'b1,
      '{12'd0, 5'd3, 1'b1, rsc_pkg::ST_NO_BELOW}},
    '{ROW_ITEM, rsc_pkg::ACT_START,   rsc_pkg::REG_CODE_MAX, 16'h0000, 1'b0, NO_EXP},
    '{ROW_ITEM, rsc_pkg::ACT_MEASURE, rsc_pkg::REG_CODE_MAX, 16'h0000, 1'b1,
      '{12'd0, 5'd3, 1'b1, rsc_pkg::ST_NO_ABOVE}}
  };

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [rsc_pkg::RSSI_W-1:0]         in_tdata = '0;
  logic                               in_tuser = 1'b0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [rsc_pkg::OUT_DATA_W-1:0]     out_tdata;
  logic                               out_tlast;
  logic                               cfg_we = 1'b0;
  logic [rsc_pkg::CFG_ADDR_W-1:0]     cfg_addr = '0;
  logic [rsc_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;

  // Register copies as written to the block.
  logic [rsc_pkg::FINE_W-1:0]   shadow_code_max = rsc_pkg::CODE_MAX_RST;
  logic [rsc_pkg::RSSI_W-1:0]   shadow_target = '0;
  logic [rsc_pkg::COARSE_W-1:0] shadow_coarse_init = rsc_pkg::COARSE_INIT_RST;
  logic                         shadow_coarse_en = 1'b1;

  // Predicted calibration state.
  logic [rsc_pkg::FINE_W-1:0]   cal_code = '0;
  logic [rsc_pkg::FINE_W-1:0]   cal_span = '0;
  logic                         cal_below = 1'b0;
  logic                         cal_above = 1'b0;
  logic [rsc_pkg::COARSE_W-1:0] cal_coarse = rsc_pkg::COARSE_INIT_RST;
  logic [rsc_pkg::STEP_W-1:0]   cal_step = rsc_pkg::COARSE_STEP_INIT;
  logic                         cal_running = 1'b0;
  rsc_pkg::status_t             cal_status = rsc_pkg::ST_OK;

  calib_result_t calib_expected [$];
  int mismatches = 0;
  int items_sent = 0;
  int send_idle_pct = 20;
  int recv_idle_pct = 65;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  rssi_successive_approx_calibrator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void restart_search();
    int half;
    half = (int'(shadow_code_max) + 1) >> 1;
    cal_code = half[rsc_pkg::FINE_W-1:0];
    cal_span = half[rsc_pkg::FINE_W-1:0];
    cal_below = 1'b0;
    cal_above = 1'b0;
  endfunction

  function automatic calib_result_t calib_step(rsc_pkg::action_t act,
                                               logic [rsc_pkg::RSSI_W-1:0] rssi);
    calib_result_t r;
    int adj;
    int code;
    int sum;
    logic fin;
    rsc_pkg::status_t verdict;
    fin = 1'b0;
    verdict = rsc_pkg::ST_OK;
    if (act == rsc_pkg::ACT_START) begin
      cal_coarse = shadow_coarse_init;
      cal_step = rsc_pkg::COARSE_STEP_INIT;
      cal_running = 1'b1;
      cal_status = rsc_pkg::ST_OK;
      restart_search();
    end else if (cal_running) begin
      adj = int'(cal_span) >> 1;
      code = int'(cal_code);
      if (rssi < shadow_target) begin
        cal_below = 1'b1;
        code = (adj > code) ? 0 : code - adj;
      end else begin
        cal_above = 1'b1;
        code = code + adj;
      end
      if (code > int'(shadow_code_max)) code = int'(shadow_code_max);
      cal_code = code[rsc_pkg::FINE_W-1:0];
      cal_span = cal_span >> 1;
      if (cal_span == '0) begin
        verdict = !cal_below ? rsc_pkg::ST_NO_BELOW
                             : (!cal_above ? rsc_pkg::ST_NO_ABOVE : rsc_pkg::ST_OK);
        if (verdict == rsc_pkg::ST_OK || !shadow_coarse_en) begin
          fin = 1'b1;
        end else if (verdict == rsc_pkg::ST_NO_BELOW) begin
          if (cal_coarse == '0 || cal_step == '0) begin
            verdict = rsc_pkg::ST_COARSE_FAIL;
            fin = 1'b1;
          end else begin
            cal_coarse = ({1'b0, cal_step} > cal_coarse) ? '0 : cal_coarse - {1'b0, cal_step};
            cal_step = cal_step >> 1;
            restart_search();
          end
        end else begin
          if (cal_coarse == rsc_pkg::COARSE_MAX || cal_step == '0) begin
            verdict = rsc_pkg::ST_COARSE_FAIL;
            fin = 1'b1;
          end else begin
            sum = int'(cal_coarse) + int'(cal_step);
            cal_coarse = (sum > int'(rsc_pkg::COARSE_MAX)) ? rsc_pkg::COARSE_MAX
                                                           : sum[rsc_pkg::COARSE_W-1:0];
            cal_step = cal_step >> 1;
            restart_search();
          end
        end
        if (fin) begin
          cal_running = 1'b0;
          cal_status = verdict;
        end
      end
    end
    r.fine = cal_code;
    r.coarse = cal_coarse;
    r.done = fin;
    r.status = fin ? cal_status : rsc_pkg::ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // Offers one transaction and waits for the block to take it. tvalid is only lowered
  // during an idle gap, so it is never both lowered and raised in one step.
  task automatic send_item(rsc_pkg::action_t act, logic [rsc_pkg::RSSI_W-1:0] rssi,
                           logic typed = 1'b0, calib_result_t want = '0);
    calib_result_t got;
    logic ignored;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= rssi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ignored = (act == rsc_pkg::ACT_MEASURE) && !cal_running;
    got = calib_step(act, rssi);
    calib_expected.push_back(typed ? want : got);
    if (!ignored) items_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (calib_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(rsc_pkg::cfg_reg_t idx, logic [rsc_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      rsc_pkg::REG_CODE_MAX:       shadow_code_max = val[rsc_pkg::FINE_W-1:0];
      rsc_pkg::REG_TARGET_RSSI:    shadow_target = val[rsc_pkg::RSSI_W-1:0];
      rsc_pkg::REG_COARSE_INITIAL: shadow_coarse_init = val[rsc_pkg::COARSE_W-1:0];
      rsc_pkg::REG_COARSE_ENABLE:  shadow_coarse_en = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_result();
    calib_result_t want;
    if (calib_expected.size() == 0) begin
      report_mismatch("unexpected result, tdata", 0, int'(out_tdata));
      return;
    end
    want = calib_expected.pop_front();
    if (out_tdata[11:0] != want.fine)
      report_mismatch("fine_code", int'(want.fine), int'(out_tdata[11:0]));
    if (out_tdata[16:12] != want.coarse)
      report_mismatch("coarse_code", int'(want.coarse), int'(out_tdata[16:12]));
    if (out_tdata[18:17] != want.status)
      report_mismatch("status", int'(want.status), int'(out_tdata[18:17]));
    if (out_tlast != want.done) report_mismatch("done", int'(want.done), int'(out_tlast));
    if (out_tdata[23:19] != '0) report_mismatch("tdata padding", 0, int'(out_tdata[23:19]));
  endtask

  // Result side: checks each transaction and drives tready, with a long hold-off on request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result();
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int cm;
    int tg;
    int ci;
    int ce;
    int phase_start;
    int style;
    int thr_code;
    int spread;
    int level;
    logic [rsc_pkg::RSSI_W-1:0] rssi;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(PLAN[i].reg_id, PLAN[i].value);
      end else begin
        send_item(PLAN[i].act, PLAN[i].value, PLAN[i].typed, PLAN[i].want);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      send_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 65 : 0;
      recv_idle_pct = (ph < 2) ? 65 : (ph < 4) ? 20 : 0;
      case (ph)
        0: begin cm = 4095; tg = 16'h8000; ci = 31; ce = 1; end
        1: begin cm = 1; tg = 0; ci = 0; ce = 0; end
        default: begin
          cm = $urandom_range(1) ? (1 << $urandom_range(12, 1)) - 1 : $urandom_range(4095, 1);
          tg = $urandom_range(65535);
          ci = $urandom_range(31);
          ce = ($urandom_range(99) < 75) ? 1 : 0;
        end
      endcase
      write_reg(rsc_pkg::REG_CODE_MAX, CFG_BITS'(cm));
      write_reg(rsc_pkg::REG_TARGET_RSSI, CFG_BITS'(tg));
      write_reg(rsc_pkg::REG_COARSE_INITIAL, CFG_BITS'(ci));
      write_reg(rsc_pkg::REG_COARSE_ENABLE, CFG_BITS'(ce));
      // Stall the result side for a while so the block backs up onto its input.
      if (ph == 2) hold_asks++;
      phase_start = items_sent;
      while (items_sent - phase_start < 70) begin
        if ($urandom_range(99) < 8) send_item(rsc_pkg::ACT_MEASURE, RSSI_BITS'($urandom));
        style = $urandom_range(2);
        // Threshold code of a simulated monotonic response; the ends force the coarse loop.
        case ($urandom_range(4))
          0: thr_code = 0;
          1: thr_code = cm + 1;
          default: thr_code = $urandom_range(cm + 1);
        endcase
        send_item(rsc_pkg::ACT_START, RSSI_BITS'($urandom));
        while (cal_running) begin
          // Now and then abandon the search; the next start must restart it.
          if ($urandom_range(99) < 3) break;
          spread = $urandom_range(255);
          case (style)
            0: begin
              if (int'(cal_code) >= thr_code) level = (tg + spread > 65535) ? 65535 : tg + spread;
              else if (tg == 0) level = $urandom_range(65535);
              else level = (spread >= tg) ? 0 : tg - 1 - spread;
            end
            1: level = $urandom_range(65535);
            default: begin
              level = tg + $urandom_range(6) - 3;
              if (level < 0) level = 0;
              if (level > 65535) level = 65535;
            end
          endcase
          rssi = level[rsc_pkg::RSSI_W-1:0];
          send_item(rsc_pkg::ACT_MEASURE, rssi);
        end
      end
    end

    drain_results();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("rssi_successive_approx_calibrator test passed");
    end else begin
      $display("rssi_successive_approx_calibrator test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("rssi_successive_approx_calibrator test failed");
    $finish;
  end

endmodule
`default_nettype wire
